// ===== rtl/gsmv_pkg.sv =====
// Package for the GF(2) sparse matrix by block vector multiplier.
// Holds the operation codes, configuration register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package gsmv_pkg;

    localparam int unsigned POS_BITS       = 16;
    localparam int unsigned COUNT_BITS     = 17;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 17;

    localparam logic [COUNT_BITS-1:0] COUNTER_MAX     = 17'h1FFFF;
    localparam logic [POS_BITS-1:0]   ROW_MARKER_RST  = 16'hFFFF;
    localparam logic [COUNT_BITS-1:0] ROW_COUNT_RST   = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_MARKER = 2'd0,
        CFG_ROW_COUNT  = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S1_ENTRY  = 2'd0,
        S1_MARKER = 2'd1,
        S1_START  = 2'd2
    } t_s1_kind;

endpackage

`default_nettype wire

// ===== rtl/gsmv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the vector word store. No dependencies.
`default_nettype none

module gsmv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gf2_sparse_matrix_block_vector_mult_core.sv =====
// A row-ending entry is registered into stage 1, which writes its result into the output buffer.
// Throughput: one item per cycle while not stalled; each non-marker entry does one read of the
// vector store RAM and, if in range, one XOR into the accumulator in the following stage.
// Results queue in a two-deep output buffer; input stalls only when that buffer could overflow.
// Reset clears the accumulator, row counter and buffer and resets the config registers; the vector
// store is not cleared and holds undefined words until loaded. Depends on gsmv_pkg and gsmv_ram.
`default_nettype none

module gf2_sparse_matrix_block_vector_mult_core
    import gsmv_pkg::*;
#(
    parameter int unsigned VECTOR_DEPTH = 65536,
    parameter int unsigned WORD_BITS    = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // item input
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_op,
    input  wire logic [POS_BITS-1:0]       i_position,
    input  wire logic [WORD_BITS-1:0]      i_load_word,
    // result output
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [POS_BITS-1:0]       o_row_idx,
    output logic      [WORD_BITS-1:0]      o_row_value,
    output logic                           o_row_overflow,
    // configuration
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int unsigned ADDR_BITS = $clog2(VECTOR_DEPTH);

    // configuration
    logic [POS_BITS-1:0]   r_row_marker;
    logic [COUNT_BITS-1:0] r_row_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_marker <= ROW_MARKER_RST;
            r_row_count  <= ROW_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROW_MARKER: r_row_marker <= i_cfg_data[POS_BITS-1:0];
                CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: accept, store write or read issue
    logic                          w_accept;
    logic                          w_is_marker;
    logic                          w_in_range;
    logic [ADDR_BITS+POS_BITS-1:0] w_pos_ext;
    logic [ADDR_BITS-1:0]          w_addr;
    logic                          w_ram_wr;
    logic                          w_ram_rd;
    logic [WORD_BITS-1:0]          w_rd_data;
    logic                          w_s0_busy;
    t_s1_kind                      w_s0_kind;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_pos_ext   = {ADDR_BITS'(0), i_position};
    assign w_addr      = w_pos_ext[ADDR_BITS-1:0];
    assign w_in_range  = 32'(i_position) < 32'(VECTOR_DEPTH);
    assign w_is_marker = i_position == r_row_marker;

    always_comb begin
        w_ram_wr  = 1'b0;
        w_ram_rd  = 1'b0;
        w_s0_busy = 1'b0;
        w_s0_kind = S1_ENTRY;
        unique case (t_op'(i_op))
            OP_LOAD: begin
                w_ram_wr = w_accept && w_in_range;
            end
            OP_ENTRY: begin
                w_s0_busy = 1'b1;
                if (w_is_marker) begin
                    w_s0_kind = S1_MARKER;
                end else begin
                    w_ram_rd = w_accept;
                end
            end
            OP_START: begin
                w_s0_busy = 1'b1;
                w_s0_kind = S1_START;
            end
            OP_NONE: ;
        endcase
    end

    gsmv_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (w_addr),
        .i_wr_data (i_load_word),
        .i_rd_en   (w_ram_rd),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // stage 1: accumulate, emit, clear
    logic     r_s1_valid;
    t_s1_kind r_s1_kind;
    logic     r_s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && w_s0_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind     <= w_s0_kind;
            r_s1_in_range <= w_in_range;
        end
    end

    logic [WORD_BITS-1:0]  r_acc;
    logic [WORD_BITS-1:0]  n_acc;
    logic [COUNT_BITS-1:0] r_row_counter;
    logic [COUNT_BITS-1:0] n_row_counter;
    logic                  w_push;

    always_comb begin
        n_acc         = r_acc;
        n_row_counter = r_row_counter;
        w_push        = 1'b0;
        if (r_s1_valid) begin
            unique case (r_s1_kind)
                S1_ENTRY: begin
                    n_acc = r_s1_in_range ? (r_acc ^ w_rd_data) : r_acc;
                end
                S1_MARKER: begin
                    w_push = 1'b1;
                    n_acc  = '0;
                    if (r_row_counter != COUNTER_MAX) begin
                        n_row_counter = r_row_counter + COUNT_BITS'(1);
                    end
                end
                S1_START: begin
                    n_acc         = '0;
                    n_row_counter = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_row_counter <= '0;
        end else begin
            r_acc         <= n_acc;
            r_row_counter <= n_row_counter;
        end
    end

    // output buffer: head register and skid register
    logic                 r_head_valid;
    logic                 n_head_valid;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    logic [POS_BITS-1:0]  r_head_index, n_head_index, r_skid_index, n_skid_index;
    logic [WORD_BITS-1:0] r_head_value, n_head_value, r_skid_value, n_skid_value;
    logic                 r_head_ovf, n_head_ovf, r_skid_ovf, n_skid_ovf;
    logic [POS_BITS-1:0]  w_new_index;
    logic                 w_new_ovf;
    logic                 w_pop;
    logic [1:0]           w_pending;

    assign w_new_index = r_row_counter[POS_BITS-1:0];
    assign w_new_ovf   = r_row_counter >= r_row_count;
    assign w_pop       = r_head_valid && !i_out_stall;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head_index = r_head_index;
        n_head_value = r_head_value;
        n_head_ovf   = r_head_ovf;
        n_skid_index = r_skid_index;
        n_skid_value = r_skid_value;
        n_skid_ovf   = r_skid_ovf;
        if (w_pop) begin
            n_head_valid = r_skid_valid;
            n_head_index = r_skid_index;
            n_head_value = r_skid_value;
            n_head_ovf   = r_skid_ovf;
            n_skid_valid = 1'b0;
        end
        if (w_push) begin
            if (!n_head_valid) begin
                n_head_valid = 1'b1;
                n_head_index = w_new_index;
                n_head_value = r_acc;
                n_head_ovf   = w_new_ovf;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_index = w_new_index;
                n_skid_value = r_acc;
                n_skid_ovf   = w_new_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_index <= n_head_index;
        r_head_value <= n_head_value;
        r_head_ovf   <= n_head_ovf;
        r_skid_index <= n_skid_index;
        r_skid_value <= n_skid_value;
        r_skid_ovf   <= n_skid_ovf;
    end

    // room for the result in flight plus one from a new beat
    assign w_pending = 2'(r_head_valid) + 2'(r_skid_valid)
                     + 2'(r_s1_valid && r_s1_kind == S1_MARKER) - 2'(w_pop);
    assign o_in_stall = w_pending >= 2'd2;

    assign o_out_valid    = r_head_valid;
    assign o_row_idx      = r_head_index;
    assign o_row_value    = r_head_value;
    assign o_row_overflow = r_head_ovf;

    // checks
    a_no_buffer_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_skid_valid && !w_pop))
        else $error("result buffer overflow");

    a_skid_implies_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry without head entry");

    a_marker_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && t_op'(i_op) == OP_ENTRY && w_is_marker)
        |=> (r_s1_valid && r_s1_kind == S1_MARKER))
        else $error("row end beat lost before stage 1");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_kind == S1_START) |=> (r_row_counter == '0 && r_acc == '0))
        else $error("start did not clear counter and accumulator");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_out_valid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== bench/tb_gf2_sparse_matrix_block_vector_mult_core.sv =====
// Self-checking bench for gf2_sparse_matrix_block_vector_mult_core: loads vector words,
// streams matrix rows under random gaps and stalls, and checks every row result.
// Depends on gsmv_pkg and the core RTL only.
module tb_gf2_sparse_matrix_block_vector_mult_core
    import gsmv_pkg::*;
;
    localparam int unsigned WORD_W = 64;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [POS_BITS-1:0] index;
        logic [WORD_W-1:0]   value;
        logic                overflow;
    } t_row;

    // expected rows of the running product, worked out per accepted beat
    class t_product_rows;
        logic [WORD_W-1:0]     words[int unsigned];
        logic [WORD_W-1:0]     acc;
        logic [COUNT_BITS-1:0] row_no;
        logic [POS_BITS-1:0]   marker;
        logic [COUNT_BITS-1:0] row_limit;
        t_row                  due_rows[$];
        int unsigned           errors;

        function new();
            acc       = '0;
            row_no    = '0;
            marker    = ROW_MARKER_RST;
            row_limit = ROW_COUNT_RST;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
            if (index == CFG_ROW_MARKER) begin
                marker = data[POS_BITS-1:0];
            end else if (index == CFG_ROW_COUNT) begin
                row_limit = data[COUNT_BITS-1:0];
            end
        endfunction

        function void note_item(t_op op, logic [POS_BITS-1:0] pos, logic [WORD_W-1:0] word);
            t_row r;
            case (op)
                OP_LOAD: begin
                    words[pos] = word;
                end
                OP_START: begin
                    row_no = '0;
                    acc    = '0;
                end
                OP_ENTRY: begin
                    if (pos == marker) begin
                        r.index    = row_no[POS_BITS-1:0];
                        r.value    = acc;
                        r.overflow = (row_no >= row_limit);
                        due_rows.push_back(r);
                        acc = '0;
                        if (row_no != COUNTER_MAX) row_no = row_no + COUNT_BITS'(1);
                    end else if (words.exists(pos)) begin
                        acc = acc ^ words[pos];
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_row(logic [POS_BITS-1:0] index, logic [WORD_W-1:0] value, logic ovf);
            t_row e;
            if (due_rows.size() == 0) begin
                $display("%0t: unexpected row, index %0d value %h overflow %b",
                         $time, index, value, ovf);
                errors++;
                return;
            end
            e = due_rows.pop_front();
            if (index !== e.index) begin
                $display("%0t: row idx expected %0d got %0d", $time, e.index, index);
                errors++;
            end
            if (value !== e.value) begin
                $display("%0t: row_value expected %h got %h", $time, e.value, value);
                errors++;
            end
            if (ovf !== e.overflow) begin
                $display("%0t: row_overflow expected %b got %b", $time, e.overflow, ovf);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_rows.size();
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_op        = OP_NONE;
    logic [POS_BITS-1:0]       i_position  = '0;
    logic [WORD_W-1:0]         i_load_word = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [POS_BITS-1:0]       o_row_idx;
    logic [WORD_W-1:0]         o_row_value;
    logic                      o_row_overflow;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    t_product_rows             book;
    logic [POS_BITS-1:0]       loaded[$];
    bit                        quiet = 1'b0;
    int unsigned               stall_left = 0;

    gf2_sparse_matrix_block_vector_mult_core #(
        .WORD_BITS(WORD_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_position     (i_position),
        .i_load_word    (i_load_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_idx      (o_row_idx),
        .o_row_value    (o_row_value),
        .o_row_overflow (o_row_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [POS_BITS-1:0] pick_col();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    function automatic logic [POS_BITS-1:0] rand_pos();
        return POS_BITS'($urandom_range(0, 65535));
    endfunction

    // result side: random stall stretches, none while quiet
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            book.check_row(o_row_idx, o_row_value, o_row_overflow);
    end

    task automatic put_item(input t_op op, input logic [POS_BITS-1:0] pos,
                            input logic [WORD_W-1:0] word);
        int unsigned gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_position  <= pos;
        i_load_word <= word;
        do @(posedge i_clk); while (o_in_stall);
        book.note_item(op, pos, word);
    endtask

    task automatic load_word(input logic [POS_BITS-1:0] pos, input logic [WORD_W-1:0] word);
        put_item(OP_LOAD, pos, word);
        loaded.push_back(pos);
    endtask

    // drain all rows, then give the pipeline time to finish non-emitting beats
    task automatic settle();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_INDEX_BITS-1:0] index,
                            input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(index, data);
    endtask

    task automatic configure(input logic [POS_BITS-1:0] marker,
                             input logic [COUNT_BITS-1:0] rows, input bit poke);
        settle();
        cfg_beat(CFG_ROW_MARKER, {1'($urandom_range(0, 1)), marker});
        cfg_beat(CFG_ROW_COUNT, rows);
        if (poke) begin
            cfg_beat(CFG_SPARE_A, CFG_DATA_BITS'($urandom_range(0, 131071)));
            cfg_beat(CFG_SPARE_B, CFG_DATA_BITS'($urandom_range(0, 131071)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_products(input int unsigned n);
        int unsigned done_items;
        int unsigned k;
        int unsigned r;
        logic [POS_BITS-1:0] col;
        done_items = 0;
        while (done_items < n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                k = $urandom_range(1, 4);
                repeat (k) load_word(rand_pos(), {$urandom, $urandom});
                done_items += k;
            end else if (r < 80) begin
                k = $urandom_range(0, 6);
                col = pick_col();
                repeat (k) begin
                    if ($urandom_range(0, 4) == 0) begin
                        col = rand_pos();
                        load_word(col, {$urandom, $urandom});
                        done_items++;
                    end else if ($urandom_range(0, 5) != 0) begin
                        col = pick_col();
                    end
                    put_item(OP_ENTRY, col, {$urandom, $urandom});
                    done_items++;
                end
                put_item(OP_ENTRY, book.marker, {$urandom, $urandom});
                done_items++;
            end else if (r < 86) begin
                put_item(OP_START, rand_pos(), {$urandom, $urandom});
                done_items++;
            end else if (r < 92) begin
                put_item(OP_NONE, rand_pos(), {$urandom, $urandom});
            end else begin
                put_item(OP_ENTRY, pick_col(), {$urandom, $urandom});
                done_items++;
            end
        end
    endtask

    initial begin
        #(4 * 1_200_000);
        $display("** gf2_sparse_matrix_block_vector_mult_core: FAILED **");
        $finish;
    end

    initial begin
        int unsigned i;
        book = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, cancelling columns, empty row, idle op, restart
        load_word(16'h0000, '1);
        load_word(16'hFFFE, '0);
        load_word(16'h5555, {32{2'b10}});
        load_word(16'hAAAA, {32{2'b01}});
        put_item(OP_ENTRY, 16'h0000, '0);
        put_item(OP_ENTRY, 16'hFFFE, '1);
        put_item(OP_ENTRY, 16'h5555, '0);
        put_item(OP_ENTRY, 16'hFFFF, '0);
        put_item(OP_ENTRY, 16'hFFFF, '1);
        put_item(OP_ENTRY, 16'hAAAA, '0);
        put_item(OP_ENTRY, 16'hAAAA, '0);
        put_item(OP_ENTRY, 16'hFFFF, '0);
        put_item(OP_NONE, 16'hFFFF, '1);
        put_item(OP_START, 16'h0000, '0);
        put_item(OP_ENTRY, 16'h5555, '0);
        put_item(OP_ENTRY, 16'hFFFF, '0);
        load_word(16'hFFFF, 64'h8000_0000_0000_0001);

        // marker 0 is also a loaded column; row count 0 flags every row
        configure(16'h0000, 17'd0, 1'b1);
        put_item(OP_ENTRY, 16'hFFFF, '0);
        put_item(OP_ENTRY, 16'h0000, '0);
        put_item(OP_START, 16'hFFFF, '1);
        put_item(OP_ENTRY, 16'h0000, '0);

        for (i = 0; i < 6; i++) begin
            case (i)
                0: configure(16'hFFFF, ROW_COUNT_RST, 1'b0);
                1: configure(16'h0000, 17'd1, 1'b0);
                2: configure(rand_pos(), COUNT_BITS'($urandom_range(2, 40)), 1'b0);
                3: configure(rand_pos(), 17'd0, 1'b1);
                4: configure(rand_pos(), COUNT_BITS'($urandom_range(0, 65536)), 1'b0);
                default: configure(rand_pos(), 17'd65535, 1'b1);
            endcase
            quiet = (i == 2);
            put_item(OP_START, rand_pos(), {$urandom, $urandom});
            run_products(310);
        end
        quiet = 1'b0;

        settle();
        if (book.errors == 0) begin
            $display("** gf2_sparse_matrix_block_vector_mult_core: PASSED **");
        end else begin
            $display("** gf2_sparse_matrix_block_vector_mult_core: FAILED **");
        end
        $finish;
    end

endmodule
